### src/imq_pkg.sv
package imq_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int IDX_W        = 10;
    localparam int PIDX_W       = 20;
    localparam int COORD_W      = 32;
    localparam int SUM_W        = 67;
    localparam int DIV_STEPS    = 65;
    localparam int SQRT_STEPS   = 32;
    localparam int SIDE_STAGES  = DIV_STEPS + SQRT_STEPS;
    localparam logic [31:0] RADIUS_RESET = 32'h0001_0000;
    localparam logic [31:0] WEIGHT_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0]
    {
        KIND_NORMAL,
        KIND_BIG,
        KIND_BIG_ONE,
        KIND_SAT
    } kind_t;

    typedef struct packed
    {
        kind_t               kind;
        logic [PIDX_W-1:0]   pidx;
    } side_t;

endpackage

### src/inverse_multiquadric_rbf_weight.sv
// Inverse multiquadric weight 1/sqrt(|p-c|^2 + r^2), unsigned Q16.16, one item per clock.
// An item is taken whenever start is high; busy is always low. The result is on done with
// weight, packed_index and saturated for one cycle, once the item has passed the difference
// register, the square register, 65 one-bit steps of a pipelined restoring divider forming
// 2^64/S (the sum is formed ahead of the first), 32 one-digit steps of a pipelined square
// root and the output register. The receiver cannot stall; results are shown for one
// cycle only. Write radius only while no item is in flight.
module inverse_multiquadric_rbf_weight
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    input  logic signed [31:0]  center_z,
    input  logic [imq_pkg::IDX_W-1:0]  row_index,
    input  logic [imq_pkg::IDX_W-1:0]  col_index,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    output logic                done,
    output logic [31:0]         weight,
    output logic [imq_pkg::PIDX_W-1:0] packed_index,
    output logic                saturated
);
    import imq_pkg::*;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_POINTS - 1);

    logic [31:0]        radius_reg;

    // stage 1
    logic               v1_reg;
    logic [32:0]        dx_reg, dy_reg, dz_reg;
    logic [31:0]        r1_reg;
    logic [IDX_W-1:0]   ilo_reg, ihi_reg;
    logic [32:0]        dx_next, dy_next, dz_next;
    logic [IDX_W-1:0]   ci_next, cj_next;

    // stage 2
    logic               v2_reg;
    logic [64:0]        sx_reg, sy_reg, sz_reg;
    logic [63:0]        rr_reg;
    logic [PIDX_W-1:0]  p2_reg;
    logic [65:0]        mx_next, my_next, mz_next;
    logic [20:0]        tri_next;

    // stage 3 sum feeding the divider
    logic [SUM_W-1:0]   sum_next;
    side_t              side0_next;

    logic [SIDE_STAGES-1:0] sval_reg;
    side_t              side_reg [SIDE_STAGES];
    logic [63:0]        drem_reg [DIV_STEPS];
    logic [63:0]        dquo_reg [DIV_STEPS];
    logic [63:0]        ddiv_reg [DIV_STEPS];
    logic [63:0]        drem_next [DIV_STEPS];
    logic [63:0]        dquo_next [DIV_STEPS];

    logic [34:0]        srem_reg [SQRT_STEPS];
    logic [31:0]        sroot_reg [SQRT_STEPS];
    logic [63:0]        sq_reg [SQRT_STEPS];
    logic [34:0]        srem_next [SQRT_STEPS];
    logic [31:0]        sroot_next [SQRT_STEPS];

    logic               done_reg;
    logic [31:0]        weight_reg;
    logic [PIDX_W-1:0]  pidx_reg;
    logic               sat_reg;
    logic [31:0]        weight_next;
    logic               sat_next;

    function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [IDX_W-1:0] ri, ci;
        dx_next = abs_diff(point_x, center_x);
        dy_next = abs_diff(point_y, center_y);
        dz_next = abs_diff(point_z, center_z);
        ri = (row_index > IDX_MAX) ? IDX_MAX : row_index;
        ci = (col_index > IDX_MAX) ? IDX_MAX : col_index;
        ci_next = (ri > ci) ? ci : ri;
        cj_next = (ri > ci) ? ri : ci;
    end

    always_comb
    begin
        mx_next  = dx_reg * dx_reg;
        my_next  = dy_reg * dy_reg;
        mz_next  = dz_reg * dz_reg;
        tri_next = 21'(ihi_reg) * (21'(ihi_reg) + 21'd1);
    end

    always_comb
    begin
        sum_next = SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg) + SUM_W'(rr_reg);
        side0_next.pidx  = p2_reg;
        if (sum_next[66:64] != 3'd0)
        begin
            side0_next.kind = (sum_next[66:64] == 3'd1 && sum_next[63:0] == 64'd0)
                              ? KIND_BIG_ONE : KIND_BIG;
        end
        else if (sum_next[63:1] == 63'd0)
        begin
            side0_next.kind = KIND_SAT;
        end
        else
        begin
            side0_next.kind = KIND_NORMAL;
        end
    end

    // restoring divide of 2^64 by the sum, one quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            logic [64:0] r2;
            logic [63:0] dv;
            logic        ge;
            if (k == 0)
            begin
                r2 = 65'd1;
                dv = sum_next[63:0];
            end
            else
            begin
                r2 = {drem_reg[k-1], 1'b0};
                dv = ddiv_reg[k-1];
            end
            ge = r2 >= {1'b0, dv};
            drem_next[k] = ge ? 64'(r2 - {1'b0, dv}) : r2[63:0];
            dquo_next[k] = (k == 0) ? {63'd0, ge} : {dquo_reg[k-1][62:0], ge};
        end
    end

    // digit-by-digit square root, one result bit per stage
    always_comb
    begin
        for (int m = 0; m < SQRT_STEPS; m++)
        begin
            logic [34:0] r2, trial;
            logic [34:0] rin;
            logic [31:0] root;
            logic [63:0] q;
            if (m == 0)
            begin
                rin  = 35'd0;
                root = 32'd0;
                q    = dquo_reg[DIV_STEPS-1];
            end
            else
            begin
                rin  = srem_reg[m-1];
                root = sroot_reg[m-1];
                q    = sq_reg[m-1];
            end
            r2    = {rin[32:0], q[63:62]};
            trial = {1'b0, root, 2'b01};
            if (r2 >= trial)
            begin
                srem_next[m]  = r2 - trial;
                sroot_next[m] = {root[30:0], 1'b1};
            end
            else
            begin
                srem_next[m]  = r2;
                sroot_next[m] = {root[30:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        side_t s;
        s = side_reg[SIDE_STAGES-1];
        sat_next = 1'b0;
        case (s.kind)
            KIND_NORMAL:  weight_next = sroot_reg[SQRT_STEPS-1];
            KIND_BIG:     weight_next = 32'd0;
            KIND_BIG_ONE: weight_next = 32'd1;
            KIND_SAT:
            begin
                weight_next = WEIGHT_MAX;
                sat_next    = 1'b1;
            end
            default:      weight_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            done_reg   <= 1'b0;
            sval_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                radius_reg <= cfg_data;
            end
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= sval_reg[SIDE_STAGES-1];
            sval_reg <= {sval_reg[SIDE_STAGES-2:0], v2_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        r1_reg  <= radius_reg;
        ilo_reg <= ci_next;
        ihi_reg <= cj_next;

        sx_reg  <= mx_next[64:0];
        sy_reg  <= my_next[64:0];
        sz_reg  <= mz_next[64:0];
        rr_reg  <= r1_reg * r1_reg;
        p2_reg  <= PIDX_W'(tri_next[20:1]) + PIDX_W'(ilo_reg);

        side_reg[0] <= side0_next;
        for (int k = 1; k < SIDE_STAGES; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end

        for (int k = 0; k < DIV_STEPS; k++)
        begin
            drem_reg[k] <= drem_next[k];
            dquo_reg[k] <= dquo_next[k];
            ddiv_reg[k] <= (k == 0) ? sum_next[63:0] : ddiv_reg[k-1];
        end

        for (int m = 0; m < SQRT_STEPS; m++)
        begin
            srem_reg[m]  <= srem_next[m];
            sroot_reg[m] <= sroot_next[m];
            sq_reg[m]    <= (m == 0) ? {dquo_reg[DIV_STEPS-1][61:0], 2'b00}
                                     : {sq_reg[m-1][61:0], 2'b00};
        end

        weight_reg <= weight_next;
        sat_reg    <= sat_next;
        pidx_reg   <= side_reg[SIDE_STAGES-1].pidx;
    end

    assign done         = done_reg;
    assign weight       = weight_reg;
    assign packed_index = pidx_reg;
    assign saturated    = sat_reg;

endmodule

### tb/inverse_multiquadric_rbf_weight_test.sv
module inverse_multiquadric_rbf_weight_test;

    timeunit 1ns;
    timeprecision 1ps;

    import imq_pkg::*;

    typedef struct
    {
        logic [31:0]       px, py, pz, cx, cy, cz;
        logic [IDX_W-1:0]  row, col;
    } pair_t;

    typedef struct
    {
        logic [31:0]        weight;
        logic [PIDX_W-1:0]  pidx;
        logic               sat;
    } weight_t;

    class weight_board;
        logic [31:0] radius;
        weight_t     pending[$];
        int          mismatches;

        function new();
            radius = RADIUS_RESET;
            mismatches = 0;
        endfunction

        function logic [63:0] dist_sq(logic [31:0] a, logic [31:0] b);
            logic signed [32:0] d;
            logic [32:0]        m;
            d = $signed({a[31], a}) - $signed({b[31], b});
            m = d[32] ? -d : d;
            return m * m;
        endfunction

        function logic [31:0] root_of(logic [63:0] q);
            logic [31:0] r;
            logic [31:0] c;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                c = r | (32'd1 << b);
                if ({32'd0, c} * {32'd0, c} <= q)
                    r = c;
            end
            return r;
        endfunction

        function void note(pair_t it);
            weight_t      e;
            logic [66:0]  s;
            logic [64:0]  q;
            logic [IDX_W-1:0] i, j;
            s = dist_sq(it.px, it.cx);
            s = s + dist_sq(it.py, it.cy);
            s = s + dist_sq(it.pz, it.cz);
            s = s + {32'd0, radius} * {32'd0, radius};
            e.sat = 0;
            if (s[66:64] != 0)
                e.weight = (s == 67'h1_0000_0000_0000_0000) ? 32'd1 : 32'd0;
            else if (s[63:0] <= 1)
            begin
                e.weight = WEIGHT_MAX;
                e.sat = 1;
            end
            else
            begin
                q = (65'd1 << 64) / {1'b0, s[63:0]};
                e.weight = root_of(q[63:0]);
            end
            i = (it.row < it.col) ? it.row : it.col;
            j = (it.row < it.col) ? it.col : it.row;
            e.pidx = PIDX_W'(i) + (PIDX_W'(j) * (PIDX_W'(j) + 1)) / 2;
            pending.push_back(e);
        endfunction

        function void check(logic [31:0] w, logic [PIDX_W-1:0] p, logic s);
            weight_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result weight=%h index=%0d sat=%b", w, p, s);
                return;
            end
            e = pending.pop_front();
            if (w !== e.weight || p !== e.pidx || s !== e.sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected weight=%h index=%0d sat=%b, got %h %0d %b",
                             e.weight, e.pidx, e.sat, w, p, s);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
    logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
    logic [IDX_W-1:0] row_index = 0, col_index = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [31:0] cfg_data = 0;
    logic done;
    logic [31:0] weight;
    logic [PIDX_W-1:0] packed_index;
    logic saturated;

    weight_board board = new();
    int idle_pct = 0;
    int cycles = 0;

    inverse_multiquadric_rbf_weight uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .center_x(center_x),
        .center_y(center_y),
        .center_z(center_z),
        .row_index(row_index),
        .col_index(col_index),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .done(done),
        .weight(weight),
        .packed_index(packed_index),
        .saturated(saturated)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        pair_t it;
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("FAIL inverse_multiquadric_rbf_weight");
            $finish;
        end
        if (rst_n && start && !busy)
        begin
            it.px = point_x; it.py = point_y; it.pz = point_z;
            it.cx = center_x; it.cy = center_y; it.cz = center_z;
            it.row = row_index; it.col = col_index;
            board.note(it);
        end
        if (rst_n && done)
            board.check(weight, packed_index, saturated);
    end

    task automatic send(pair_t it);
        start <= 1;
        point_x <= it.px; point_y <= it.py; point_z <= it.pz;
        center_x <= it.cx; center_y <= it.cy; center_z <= it.cz;
        row_index <= it.row; col_index <= it.col;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic set_radius(logic [31:0] r);
        start <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= r;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        board.radius = r;
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return 32'($signed($urandom_range(8191)) - 4096) <<< $urandom_range(16);
        endcase
    endfunction

    function automatic logic [31:0] near(logic [31:0] c);
        if ($urandom_range(3) == 0)
            return coord();
        return c + (32'($signed($urandom_range(4095)) - 2048) <<< $urandom_range(20));
    endfunction

    function automatic pair_t random_pair();
        pair_t it;
        it.cx = coord(); it.cy = coord(); it.cz = coord();
        it.px = near(it.cx); it.py = near(it.cy); it.pz = near(it.cz);
        it.row = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 10'd1023 : 10'd0)
                                          : 10'($urandom_range(1023));
        it.col = ($urandom_range(4) == 0) ? it.row : 10'($urandom_range(1023));
        return it;
    endfunction

    function automatic pair_t make(logic [31:0] px, py, pz, cx, cy, cz,
                                   logic [IDX_W-1:0] r, c);
        pair_t it;
        it.px = px; it.py = py; it.pz = pz;
        it.cx = cx; it.cy = cy; it.cz = cz;
        it.row = r; it.col = c;
        return it;
    endfunction

    initial
    begin
        logic [31:0] radii [7];
        int phase_idle [4];
        radii = '{32'h0001_0000, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                  32'h0000_0100, 32'h0};
        phase_idle = '{0, 66, 25, 0};
        repeat (7)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset radius 1.0: coincident points, extremes, index swap and corners
        send(make(0, 0, 0, 0, 0, 0, 0, 0));
        send(make(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1023, 1023));
        send(make(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1023, 0));
        send(make(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1023));
        send(make(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 5, 3));
        send(make(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 3, 5));
        set_radius(32'h0);
        send(make(32'h1234_5678, 32'h1, 32'h2, 32'h1234_5678, 32'h1, 32'h2, 7, 7));
        send(make(1, 0, 0, 0, 0, 0, 2, 9));
        send(make(0, 0, 2, 0, 0, 0, 9, 2));
        send(make(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 512, 511));
        set_radius(32'h8000_0000);
        // sum of exactly 2^64 raw
        send(make(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 100, 200));
        send(make(32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 200, 100));
        send(make(0, 0, 0, 0, 0, 0, 1, 1));
        set_radius(32'h1);
        send(make(5, 5, 5, 5, 5, 5, 0, 1));
        send(make(6, 5, 5, 5, 5, 5, 1, 0));
        set_radius(32'hFFFF_FFFF);
        send(make(0, 0, 0, 0, 0, 0, 1023, 1022));
        send(make(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));

        for (int p = 0; p < 7; p++)
        begin
            set_radius(p == 6 ? $urandom : radii[p]);
            for (int k = 0; k < 240; k++)
            begin
                idle_pct = phase_idle[(k / 60) % 4];
                send(random_pair());
            end
        end

        start <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASS inverse_multiquadric_rbf_weight");
        else
            $display("FAIL inverse_multiquadric_rbf_weight");
        $finish;
    end

endmodule
